@@ rtl/cdk_pkg.sv @@
// Shared widths, reset values, register indexes and data types of the color distance key.
`timescale 1ns / 1ps

package cdk_pkg;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 18;
  localparam int QUO_W  = 16;
  localparam int ROOT_W = 8;
  localparam int CAND_W = QUO_W + 1;
  localparam int PROD_W = 2 * SUM_W;
  localparam int CFG_W  = 8;
  localparam int IDX_W  = 3;

  // Division by three as a multiply by ceil(2^19 / 3) and a right shift; exact for sums below 2^19.
  localparam logic [SUM_W-1:0] DIV3_MULT  = 18'd174763;
  localparam int               DIV3_SHIFT = 19;

  localparam logic [PIX_W-1:0]  RESET_REF_LUMA        = 8'd100;
  localparam logic [PIX_W-1:0]  RESET_REF_CHROMA_RED  = 8'd100;
  localparam logic [PIX_W-1:0]  RESET_REF_CHROMA_BLUE = 8'd120;
  localparam logic [ROOT_W-1:0] RESET_MAX_DISTANCE    = 8'd50;
  localparam logic              RESET_THRESHOLD_EN    = 1'b0;
  localparam logic [ROOT_W-1:0] GRAY_FULL             = 8'd255;

  typedef enum logic [IDX_W-1:0] {
    CFG_REF_LUMA         = 3'd0,
    CFG_REF_CHROMA_RED   = 3'd1,
    CFG_REF_CHROMA_BLUE  = 3'd2,
    CFG_MAX_DISTANCE     = 3'd3,
    CFG_THRESHOLD_ENABLE = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_red;
    logic [PIX_W-1:0] chroma_blue;
  } ref_color_t;

  typedef struct packed {
    logic [QUO_W-1:0]  value;
    logic [ROOT_W-1:0] root;
    logic [QUO_W-1:0]  square;
  } sqrt_data_t;

endpackage

@@ rtl/cdk_if.sv @@
// Valid/ready channel interfaces for pixel transactions and gray level transactions.
`timescale 1ns / 1ps

interface cdk_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [cdk_pkg::PIX_W-1:0]  luma;
  logic [cdk_pkg::PIX_W-1:0]  chroma_red;
  logic [cdk_pkg::PIX_W-1:0]  chroma_blue;

  modport source (output valid, luma, chroma_red, chroma_blue, input ready);
  modport sink (input valid, luma, chroma_red, chroma_blue, output ready);
endinterface

interface cdk_gray_if;
  logic                       valid;
  logic                       ready;
  logic [cdk_pkg::ROOT_W-1:0] gray_level;

  modport source (output valid, gray_level, input ready);
  modport sink (input valid, gray_level, output ready);
endinterface

@@ rtl/cdk_front.sv @@
// Front stages: squared color differences summed, then the sum divided by three.
`timescale 1ns / 1ps

module cdk_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cdk_pkg::PIX_W-1:0]   luma,
  input  logic [cdk_pkg::PIX_W-1:0]   chroma_red,
  input  logic [cdk_pkg::PIX_W-1:0]   chroma_blue,
  input  cdk_pkg::ref_color_t         ref_color,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cdk_pkg::QUO_W-1:0]   quotient
);

  logic                         sum_valid;
  logic [cdk_pkg::SUM_W-1:0]    sum;
  logic [cdk_pkg::SUM_W-1:0]    sum_next;
  logic                         sum_ready;
  logic                         quo_ready;
  logic [cdk_pkg::PIX_W-1:0]    diff_y;
  logic [cdk_pkg::PIX_W-1:0]    diff_cr;
  logic [cdk_pkg::PIX_W-1:0]    diff_cb;
  logic [2*cdk_pkg::PIX_W-1:0]  sq_y;
  logic [2*cdk_pkg::PIX_W-1:0]  sq_cr;
  logic [2*cdk_pkg::PIX_W-1:0]  sq_cb;
  logic [cdk_pkg::PROD_W-1:0]   product;

  always_comb begin
    diff_y  = (luma >= ref_color.luma) ? luma - ref_color.luma : ref_color.luma - luma;
    diff_cr = (chroma_red >= ref_color.chroma_red) ? chroma_red - ref_color.chroma_red
                                                   : ref_color.chroma_red - chroma_red;
    diff_cb = (chroma_blue >= ref_color.chroma_blue) ? chroma_blue - ref_color.chroma_blue
                                                     : ref_color.chroma_blue - chroma_blue;
    sq_y  = {8'd0, diff_y} * {8'd0, diff_y};
    sq_cr = {8'd0, diff_cr} * {8'd0, diff_cr};
    sq_cb = {8'd0, diff_cb} * {8'd0, diff_cb};
    sum_next = {2'd0, sq_y} + {2'd0, sq_cr} + {2'd0, sq_cb};
    product = {{cdk_pkg::SUM_W{1'b0}}, sum}
            * {{cdk_pkg::SUM_W{1'b0}}, cdk_pkg::DIV3_MULT};
  end

  assign quo_ready = !out_valid || out_ready;
  assign sum_ready = !sum_valid || quo_ready;
  assign in_ready  = sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid <= in_valid;
      end
      if (quo_ready) begin
        out_valid <= sum_valid;
      end
    end
    if (sum_ready) begin
      sum <= sum_next;
    end
    if (quo_ready) begin
      quotient <= product[cdk_pkg::DIV3_SHIFT +: cdk_pkg::QUO_W];
    end
  end

endmodule

@@ rtl/cdk_sqrt_cell.sv @@
// One cell of the square root chain: decides one root bit and hands the result onward.
`timescale 1ns / 1ps

module cdk_sqrt_cell #(
  parameter int BIT_POS = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdk_pkg::sqrt_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cdk_pkg::sqrt_data_t out_data
);

  logic [cdk_pkg::CAND_W-1:0] cand;
  logic                       take;
  cdk_pkg::sqrt_data_t        data_next;

  always_comb begin
    cand = {1'b0, in_data.square}
         + ({{(cdk_pkg::CAND_W-cdk_pkg::ROOT_W){1'b0}}, in_data.root} << (BIT_POS + 1))
         + ({{(cdk_pkg::CAND_W-1){1'b0}}, 1'b1} << (2 * BIT_POS));
    take = cand <= {1'b0, in_data.value};
    data_next.value  = in_data.value;
    data_next.root   = take ? in_data.root | (cdk_pkg::ROOT_W'(1) << BIT_POS) : in_data.root;
    data_next.square = take ? cand[cdk_pkg::QUO_W-1:0] : in_data.square;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_data <= data_next;
    end
  end

  a_square_tracks_root: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.square ==
      ({{cdk_pkg::ROOT_W{1'b0}}, out_data.root} * {{cdk_pkg::ROOT_W{1'b0}}, out_data.root}))
    else $error("Running square does not match the partial root.");

  a_square_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.square <= out_data.value)
    else $error("Partial root squared exceeds the operand.");

  a_low_bits_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.root & ((cdk_pkg::ROOT_W'(1) << BIT_POS) - cdk_pkg::ROOT_W'(1)))
                  == '0)
    else $error("Root bits below this cell are already set.");

endmodule

@@ rtl/color_distance_key.sv @@
// Top level of the color distance key: configuration, front stages, square root chain, output.
//
// A pixel transaction on the pixel channel (luma, chroma_red, chroma_blue) yields exactly one
// gray level transaction on the gray channel, in order. The gray level is the root-mean-square
// distance of the pixel to the reference color, forced to 255 when keying is enabled and the
// distance exceeds max_distance.
// The datapath is a pipeline of eleven registered stages: the summed squared differences, the
// division by three, eight square root cells that each settle one root bit, and the output
// register, which drives gray.valid. One pixel is accepted in every cycle while the gray channel
// does not stall.
// Every stage holds its transaction when the stage after it is full and stalled, so a stalled
// receiver fills the bubbles first and then drops pixel.ready; nothing is lost or repeated.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at once. They must be
// made by the user while no pixel is in flight (not enforced); unknown-index writes are ignored.
// A synchronous reset empties the pipeline and restores the register reset values: reference
// color (100, 100, 120), max_distance 50 and keying disabled.
`timescale 1ns / 1ps

module color_distance_key (
  input  logic                      clk,
  input  logic                      rst,
  cdk_pixel_if.sink                 pixel,
  cdk_gray_if.source                gray,
  input  logic                      cfg_we,
  input  logic [cdk_pkg::IDX_W-1:0] cfg_index,
  input  logic [cdk_pkg::CFG_W-1:0] cfg_data
);

  cdk_pkg::ref_color_t          ref_color;
  logic [cdk_pkg::ROOT_W-1:0]   max_distance;
  logic                         threshold_enable;
  logic                         front_valid;
  logic                         front_ready;
  logic [cdk_pkg::QUO_W-1:0]    quotient;
  logic                         link_valid [cdk_pkg::ROOT_W+1];
  logic                         link_ready [cdk_pkg::ROOT_W+1];
  cdk_pkg::sqrt_data_t          link_data  [cdk_pkg::ROOT_W+1];
  logic                         out_ready;
  logic [cdk_pkg::ROOT_W-1:0]   root;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_color.luma        <= cdk_pkg::RESET_REF_LUMA;
      ref_color.chroma_red  <= cdk_pkg::RESET_REF_CHROMA_RED;
      ref_color.chroma_blue <= cdk_pkg::RESET_REF_CHROMA_BLUE;
      max_distance          <= cdk_pkg::RESET_MAX_DISTANCE;
      threshold_enable      <= cdk_pkg::RESET_THRESHOLD_EN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdk_pkg::CFG_REF_LUMA:         ref_color.luma        <= cfg_data;
        cdk_pkg::CFG_REF_CHROMA_RED:   ref_color.chroma_red  <= cfg_data;
        cdk_pkg::CFG_REF_CHROMA_BLUE:  ref_color.chroma_blue <= cfg_data;
        cdk_pkg::CFG_MAX_DISTANCE:     max_distance          <= cfg_data;
        cdk_pkg::CFG_THRESHOLD_ENABLE: threshold_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cdk_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (pixel.valid),
    .in_ready    (pixel.ready),
    .luma        (pixel.luma),
    .chroma_red  (pixel.chroma_red),
    .chroma_blue (pixel.chroma_blue),
    .ref_color   (ref_color),
    .out_valid   (front_valid),
    .out_ready   (front_ready),
    .quotient    (quotient)
  );

  assign link_valid[0]        = front_valid;
  assign front_ready          = link_ready[0];
  assign link_data[0].value   = quotient;
  assign link_data[0].root    = '0;
  assign link_data[0].square  = '0;

  for (genvar g = 0; g < cdk_pkg::ROOT_W; g++) begin : g_cell
    cdk_sqrt_cell #(
      .BIT_POS (cdk_pkg::ROOT_W - 1 - g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_data   (link_data[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_data  (link_data[g+1])
    );
  end

  assign root                         = link_data[cdk_pkg::ROOT_W].root;
  assign out_ready                    = !gray.valid || gray.ready;
  assign link_ready[cdk_pkg::ROOT_W]  = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray.valid <= 1'b0;
    end else if (out_ready) begin
      gray.valid <= link_valid[cdk_pkg::ROOT_W];
    end
    if (out_ready) begin
      gray.gray_level <= (threshold_enable && root > max_distance) ? cdk_pkg::GRAY_FULL : root;
    end
  end

endmodule

@@ tb/color_distance_key_tb.sv @@
// Self-checking testbench for the color distance key under random flow control on both channels.
`timescale 1ns / 1ps

module color_distance_key_tb;

  typedef struct packed {
    logic [cdk_pkg::PIX_W-1:0] luma;
    logic [cdk_pkg::PIX_W-1:0] chroma_red;
    logic [cdk_pkg::PIX_W-1:0] chroma_blue;
  } pixel_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [cdk_pkg::IDX_W-1:0] cfg_index = '0;
  logic [cdk_pkg::CFG_W-1:0] cfg_data = '0;

  cdk_pixel_if pixel_ch ();
  cdk_gray_if  gray_ch ();

  color_distance_key u_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel_ch),
    .gray      (gray_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Local copy of the key settings, updated as each register write is issued.
  cdk_pkg::ref_color_t        key_color;
  logic [cdk_pkg::ROOT_W-1:0] key_max_distance;
  logic                       key_threshold_on;

  pixel_t                     pixels_to_send[$];
  logic [cdk_pkg::ROOT_W-1:0] gray_expected[$];
  pixel_t                     next_pixel;
  logic [cdk_pkg::ROOT_W-1:0] want_gray;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pixels_sent = 0;
  int grays_checked = 0;
  int mismatch_count = 0;
  int settings_count = 0;

  function automatic logic [cdk_pkg::ROOT_W-1:0] predict_gray(pixel_t px);
    int dy;
    int dcr;
    int dcb;
    int mean_sq;
    int root;
    int trial;
    dy = int'(px.luma) - int'(key_color.luma);
    dcr = int'(px.chroma_red) - int'(key_color.chroma_red);
    dcb = int'(px.chroma_blue) - int'(key_color.chroma_blue);
    mean_sq = (dy * dy + dcr * dcr + dcb * dcb) / 3;
    root = 0;
    for (int b = cdk_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= mean_sq) root = trial;
    end
    if (root > int'(cdk_pkg::GRAY_FULL) ||
        (key_threshold_on && root > int'(key_max_distance))) begin
      return cdk_pkg::GRAY_FULL;
    end
    return root[cdk_pkg::ROOT_W-1:0];
  endfunction

  task automatic note_mismatch(string what, int want_v, int got_v);
    if (mismatch_count < 10) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.valid <= 1'b0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        gray_expected = {gray_expected,
                         predict_gray(pixel_t'({pixel_ch.luma, pixel_ch.chroma_red,
                                                pixel_ch.chroma_blue}))};
        pixels_sent++;
      end
      if (!pixel_ch.valid || pixel_ch.ready) begin
        if (pixels_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pixel = pixels_to_send.pop_front();
          pixel_ch.valid       <= 1'b1;
          pixel_ch.luma        <= next_pixel.luma;
          pixel_ch.chroma_red  <= next_pixel.chroma_red;
          pixel_ch.chroma_blue <= next_pixel.chroma_blue;
        end else begin
          pixel_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      gray_ch.ready <= 1'b0;
    end else begin
      if (gray_ch.valid && gray_ch.ready) begin
        if (gray_expected.size() == 0) begin
          note_mismatch("Gray level transaction with nothing pending", -1,
                        int'(gray_ch.gray_level));
        end else begin
          want_gray = gray_expected.pop_front();
          grays_checked++;
          if (gray_ch.gray_level !== want_gray) begin
            note_mismatch("Mismatch on gray_level", int'(want_gray), int'(gray_ch.gray_level));
          end
        end
      end
      gray_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [cdk_pkg::IDX_W-1:0] idx, logic [cdk_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      cdk_pkg::CFG_REF_LUMA:         key_color.luma = data;
      cdk_pkg::CFG_REF_CHROMA_RED:   key_color.chroma_red = data;
      cdk_pkg::CFG_REF_CHROMA_BLUE:  key_color.chroma_blue = data;
      cdk_pkg::CFG_MAX_DISTANCE:     key_max_distance = data;
      cdk_pkg::CFG_THRESHOLD_ENABLE: key_threshold_on = data[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_key(logic [cdk_pkg::PIX_W-1:0] y, logic [cdk_pkg::PIX_W-1:0] cr,
                         logic [cdk_pkg::PIX_W-1:0] cb, logic [cdk_pkg::ROOT_W-1:0] max_d,
                         logic thr_on);
    logic [cdk_pkg::CFG_W-1:0] thr_data;
    thr_data = cdk_pkg::CFG_W'($urandom);
    thr_data[0] = thr_on;
    write_reg(cdk_pkg::CFG_REF_LUMA, y);
    write_reg(cdk_pkg::CFG_REF_CHROMA_RED, cr);
    write_reg(cdk_pkg::CFG_REF_CHROMA_BLUE, cb);
    write_reg(cdk_pkg::CFG_MAX_DISTANCE, max_d);
    write_reg(cdk_pkg::CFG_THRESHOLD_ENABLE, thr_data);
    end_writes();
    settings_count++;
  endtask

  task automatic queue_pixel(logic [cdk_pkg::PIX_W-1:0] y, logic [cdk_pkg::PIX_W-1:0] cr,
                             logic [cdk_pkg::PIX_W-1:0] cb);
    pixels_to_send = {pixels_to_send, pixel_t'({y, cr, cb})};
  endtask

  function automatic logic [cdk_pkg::PIX_W-1:0] near_value(logic [cdk_pkg::PIX_W-1:0] center,
                                                           int spread);
    int v;
    v = int'(center) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[cdk_pkg::PIX_W-1:0];
  endfunction

  function automatic logic [cdk_pkg::PIX_W-1:0] rand_pix();
    return cdk_pkg::PIX_W'($urandom_range(255));
  endfunction

  // Half the pixels are uniform; the rest sit near the reference color so that the
  // keying threshold is crossed from both sides.
  task automatic queue_random_pixels(int count);
    int spread;
    spread = int'(key_max_distance) + 2;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1) == 0) begin
        queue_pixel(rand_pix(), rand_pix(), rand_pix());
      end else begin
        queue_pixel(near_value(key_color.luma, spread), near_value(key_color.chroma_red, spread),
                    near_value(key_color.chroma_blue, spread));
      end
    end
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (pixels_to_send.size() != 0 || pixel_ch.valid || gray_expected.size() != 0);
  endtask

  initial begin
    pixel_ch.valid       = 1'b0;
    pixel_ch.luma        = '0;
    pixel_ch.chroma_red  = '0;
    pixel_ch.chroma_blue = '0;
    gray_ch.ready        = 1'b0;
    key_color.luma        = cdk_pkg::RESET_REF_LUMA;
    key_color.chroma_red  = cdk_pkg::RESET_REF_CHROMA_RED;
    key_color.chroma_blue = cdk_pkg::RESET_REF_CHROMA_BLUE;
    key_max_distance      = cdk_pkg::RESET_MAX_DISTANCE;
    key_threshold_on      = cdk_pkg::RESET_THRESHOLD_EN;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 16;
    recv_idle_pct = 50;
    settings_count = 1;
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd100, 8'd100, 8'd120);
    queue_pixel(8'd255, 8'd0, 8'd255);
    queue_pixel(8'd0, 8'd255, 8'd0);
    queue_pixel(8'hAA, 8'h55, 8'hAA);
    queue_pixel(8'h55, 8'hAA, 8'h55);
    queue_pixel(8'd101, 8'd99, 8'd121);
    drain();

    // Writes to indexes past the last register must leave the settings alone.
    for (int idx = int'(cdk_pkg::CFG_THRESHOLD_ENABLE) + 1; idx < (1 << cdk_pkg::IDX_W);
         idx++) begin
      write_reg(cdk_pkg::IDX_W'(idx), cdk_pkg::CFG_W'($urandom));
    end
    end_writes();
    queue_pixel(8'd0, 8'd255, 8'd0);
    queue_pixel(8'd100, 8'd100, 8'd125);
    drain();

    // A gray pixel at (a, a, a) against a black reference is exactly a away.
    set_key(8'd0, 8'd0, 8'd0, 8'd50, 1'b1);
    queue_pixel(8'd50, 8'd50, 8'd50);
    queue_pixel(8'd51, 8'd51, 8'd51);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    drain();
    set_key(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd1, 8'd1, 8'd1);
    drain();
    set_key(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd254, 8'd254, 8'd254);
    drain();
    set_key(8'd255, 8'd0, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd0);
    drain();

    set_key(rand_pix(), rand_pix(), rand_pix(), rand_pix(), 1'b0);
    queue_random_pixels(100);
    drain();
    set_key(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    queue_random_pixels(100);
    drain();
    set_key(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    queue_random_pixels(100);
    drain();

    send_idle_pct = 50;
    recv_idle_pct = 16;
    set_key(rand_pix(), rand_pix(), rand_pix(), rand_pix(), 1'b1);
    queue_random_pixels(100);
    drain();
    set_key(8'd128, 8'd128, 8'd128, 8'd100, 1'b1);
    queue_random_pixels(100);
    drain();
    set_key(rand_pix(), rand_pix(), rand_pix(), rand_pix(), 1'b0);
    queue_random_pixels(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_key(rand_pix(), rand_pix(), rand_pix(), cdk_pkg::ROOT_W'($urandom_range(64)), 1'b1);
    queue_random_pixels(100);
    drain();
    set_key(rand_pix(), rand_pix(), rand_pix(), rand_pix(), 1'b1);
    queue_random_pixels(100);
    drain();

    repeat (20) @(posedge clk);
    $display("Covered %0d pixel transactions and %0d gray level checks over %0d key settings.",
             pixels_sent, grays_checked, settings_count);
    $display("Mismatches seen: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d gray level transactions still pending.", gray_expected.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
